FILE: rtl/fan_lvl_pkg.sv
// Shared types, codes and constants of the fan level command parser.
package fan_lvl_pkg;

    // Collection mode of the parser
    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_CUR  = 2'd1,
        MODE_DEF  = 2'd2
    } mode_t;

    // Result sequence started by one accepted input transfer
    typedef enum logic [2:0] {
        SEQ_NONE  = 3'd0,
        SEQ_ONE   = 3'd1,
        SEQ_IDENT = 3'd2,
        SEQ_CUR   = 3'd3,
        SEQ_DEF   = 3'd4
    } seq_t;

    // Kind of one result transfer
    typedef enum logic [1:0] {
        RK_TX    = 2'd0,
        RK_APPLY = 2'd1,
        RK_STORE = 2'd2,
        RK_RESET = 2'd3
    } result_kind_t;

    // Controller states
    typedef enum logic {
        CTL_IDLE = 1'b0,
        CTL_EMIT = 1'b1
    } ctl_state_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_SILENCE_LIMIT = 2'd0,
        CFG_PWM_OFFSET    = 2'd1,
        CFG_OFF_THRESHOLD = 2'd2
    } cfg_index_t;

    // Port widths
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 24;
    localparam int M_TUSER_W  = 2;

    // Command bytes and fixed values
    localparam logic [7:0]  BYTE_IDENT     = 8'd255;
    localparam logic [7:0]  BYTE_START_CUR = 8'd107;
    localparam logic [7:0]  BYTE_START_DEF = 8'd125;
    localparam logic [7:0]  LEVEL_LIMIT    = 8'd101;
    localparam logic [7:0]  BYTE_SET_DONE  = 8'd120;
    localparam logic [15:0] SILENCE_MAX    = 16'hFFFF;
    localparam int          IDENT_LEN      = 12;

    // Register reset values
    localparam logic [15:0] SILENCE_LIMIT_RST = 16'd800;
    localparam logic [7:0]  PWM_OFFSET_RST    = 8'd155;
    localparam logic [6:0]  OFF_THRESHOLD_RST = 7'd2;

    // Identification reply, one byte per step
    function automatic logic [7:0] ident_byte(input logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'd125;
            4'd1:    b = 8'd150;
            4'd2:    b = 8'd10;
            4'd3:    b = 8'd20;
            4'd4:    b = 8'd30;
            4'd5:    b = 8'd40;
            4'd6:    b = 8'd50;
            4'd7:    b = 8'd60;
            4'd8:    b = 8'd70;
            4'd9:    b = 8'd80;
            4'd10:   b = 8'd35;
            4'd11:   b = 8'd36;
            default: b = 8'd0;
        endcase
        return b;
    endfunction

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic load;
        logic last;
        seq_t seq;
    } ctl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        seq_t act_seq;
        logic out_free;
    } dp_status_t;

endpackage

FILE: rtl/fan_level_command_parser_top.sv
// Fan level command parser: one input transfer in, a short sequence of results out.
// An input transfer is taken while the block is idle; the controller state register then
// moves to emitting and the first result is loaded into the output register, which offers
// it; the rest follow one per cycle, slowed only by output back-pressure.
// A byte with no result leaves the block idle; otherwise no new input transfer is taken
// until the last result of its sequence has been loaded into the output register.
// Reset (aresetn low, synchronous) clears control state, current levels and restores
// register defaults; the default level store is not cleared.
module fan_level_command_parser_top #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration write port
    input  logic                                cfg_we,
    input  logic [fan_lvl_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [fan_lvl_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // Input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [fan_lvl_pkg::S_TDATA_W-1:0]   s_tdata,  // [7:0] rx_byte
    input  logic                                s_tuser,  // [0] kind
    // Result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [7:0] tx_byte, [10:8] channel, [18:11] level, [19] enable, [23:20] zero
    output logic [fan_lvl_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [fan_lvl_pkg::M_TUSER_W-1:0]   m_tuser,  // [1:0] result_kind
    output logic                                m_tlast   // last
);
    import fan_lvl_pkg::*;

    localparam int SEQ_STEPS = (NUM_CHANNELS + 2 > IDENT_LEN) ? NUM_CHANNELS + 2 : IDENT_LEN;
    localparam int STEP_W    = $clog2(SEQ_STEPS);

    ctl_cmd_t          cmd;
    dp_status_t        status;
    logic [STEP_W-1:0] step;

    // Sequencer
    fan_lvl_ctrl #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .STEP_W       (STEP_W)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd),
        .step     (step)
    );

    // State, stores and output register
    fan_lvl_dp #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .STEP_W       (STEP_W)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .step      (step),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

FILE: rtl/fan_lvl_ctrl.sv
// Controller state machine: input handshake and result sequencing.
module fan_lvl_ctrl #(
    parameter int NUM_CHANNELS = 8,
    parameter int STEP_W       = 4
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  fan_lvl_pkg::dp_status_t status,
    output fan_lvl_pkg::ctl_cmd_t   cmd,
    output logic [STEP_W-1:0]      step
);
    import fan_lvl_pkg::*;

    ctl_state_t        state_reg, state_next;
    seq_t              seq_reg, seq_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [STEP_W-1:0] last_step;

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CTL_IDLE;
            seq_reg   <= SEQ_NONE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            seq_reg   <= seq_next;
            step_reg  <= step_next;
        end
    end

    // Index of the final result of the running sequence
    always_comb begin
        case (seq_reg)
            SEQ_ONE:   last_step = '0;
            SEQ_IDENT: last_step = STEP_W'(IDENT_LEN - 1);
            default:   last_step = STEP_W'(NUM_CHANNELS + 1);
        endcase
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        seq_next   = seq_reg;
        step_next  = step_reg;
        s_tready   = 1'b0;
        cmd.accept = 1'b0;
        cmd.load   = 1'b0;
        cmd.last   = (step_reg == last_step);
        cmd.seq    = seq_reg;
        case (state_reg)
            CTL_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    if (status.act_seq != SEQ_NONE) begin
                        seq_next   = status.act_seq;
                        step_next  = '0;
                        state_next = CTL_EMIT;
                    end
                end
            end
            CTL_EMIT: begin
                // One result per cycle whenever the output register can take it
                if (status.out_free) begin
                    cmd.load = 1'b1;
                    if (step_reg == last_step) begin
                        state_next = CTL_IDLE;
                    end else begin
                        step_next = step_reg + 1'b1;
                    end
                end
            end
            default: state_next = CTL_IDLE;
        endcase
    end

    assign step = step_reg;

endmodule

FILE: rtl/fan_lvl_dp.sv
// Datapath: configuration, parser state, level stores and output register.
module fan_lvl_dp #(
    parameter int NUM_CHANNELS = 8,
    parameter int STEP_W       = 4
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [fan_lvl_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [fan_lvl_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                                s_tuser,
    input  logic [fan_lvl_pkg::S_TDATA_W-1:0]   s_tdata,
    input  fan_lvl_pkg::ctl_cmd_t                cmd,
    input  logic [STEP_W-1:0]                   step,
    output fan_lvl_pkg::dp_status_t              status,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [fan_lvl_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [fan_lvl_pkg::M_TUSER_W-1:0]   m_tuser,
    output logic                                m_tlast
);
    import fan_lvl_pkg::*;

    localparam int IDX_W = $clog2(NUM_CHANNELS);

    // Configuration registers
    logic [15:0] silence_limit_reg;
    logic [7:0]  pwm_offset_reg;
    logic [6:0]  off_threshold_reg;

    // Parser state
    mode_t        mode_reg, mode_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic [15:0]  silence_reg, silence_next;
    logic [6:0]   cur_reg [NUM_CHANNELS];
    logic [6:0]   def_mem [NUM_CHANNELS];
    logic [7:0]   echo_reg, echo_next;
    result_kind_t single_kind_reg, single_kind_next;

    // Input decode
    logic [7:0]   rx;
    logic [15:0]  silence_inc;
    logic         tick_fire;
    logic         store_level;
    logic         clear_levels;
    seq_t         act_seq;

    // Output register
    logic         m_valid_reg;
    result_kind_t out_kind_reg, res_kind;
    logic [7:0]   out_tx_reg, res_tx;
    logic [2:0]   out_ch_reg, res_ch;
    logic [7:0]   out_lvl_reg, res_lvl;
    logic         out_en_reg, res_en;
    logic         out_last_reg;

    // Result generation
    logic [STEP_W-1:0] ch_full;
    logic [IDX_W-1:0]  ch_idx;
    logic [6:0]        lvl_cur, lvl_def;
    logic              cur_on, pwm_ch;
    logic [8:0]        pwm_sum;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            silence_limit_reg <= SILENCE_LIMIT_RST;
            pwm_offset_reg    <= PWM_OFFSET_RST;
            off_threshold_reg <= OFF_THRESHOLD_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_SILENCE_LIMIT: silence_limit_reg <= cfg_wdata;
                CFG_PWM_OFFSET:    pwm_offset_reg    <= cfg_wdata[7:0];
                CFG_OFF_THRESHOLD: off_threshold_reg <= cfg_wdata[6:0];
                default:           ;
            endcase
        end
    end

    // Decode of the offered input transfer and the state it leaves
    assign rx          = s_tdata;
    assign silence_inc = (silence_reg == SILENCE_MAX) ? silence_reg : silence_reg + 16'd1;
    assign tick_fire   = (silence_inc > silence_limit_reg);

    always_comb begin
        mode_next        = mode_reg;
        slot_next        = slot_reg;
        silence_next     = silence_reg;
        echo_next        = echo_reg;
        single_kind_next = single_kind_reg;
        store_level      = 1'b0;
        clear_levels     = 1'b0;
        act_seq          = SEQ_NONE;
        if (s_tuser) begin
            // Timer tick
            silence_next = silence_inc;
            if (tick_fire) begin
                act_seq          = SEQ_ONE;
                single_kind_next = RK_RESET;
                mode_next        = MODE_IDLE;
                slot_next        = '0;
                silence_next     = '0;
                clear_levels     = 1'b1;
            end
        end else if (rx == BYTE_IDENT) begin
            act_seq      = SEQ_IDENT;
            mode_next    = MODE_IDLE;
            silence_next = '0;
        end else if (rx == BYTE_START_CUR || rx == BYTE_START_DEF) begin
            act_seq          = SEQ_ONE;
            single_kind_next = RK_TX;
            echo_next        = rx;
            silence_next     = '0;
            slot_next        = '0;
            mode_next        = (rx == BYTE_START_CUR) ? MODE_CUR : MODE_DEF;
        end else if (rx < LEVEL_LIMIT && (mode_reg == MODE_CUR || mode_reg == MODE_DEF)) begin
            store_level  = 1'b1;
            silence_next = '0;
            echo_next    = rx;
            if (slot_reg == IDX_W'(NUM_CHANNELS - 1)) begin
                act_seq   = (mode_reg == MODE_CUR) ? SEQ_CUR : SEQ_DEF;
                slot_next = '0;
                mode_next = MODE_IDLE;
            end else begin
                act_seq          = SEQ_ONE;
                single_kind_next = RK_TX;
                slot_next        = slot_reg + 1'b1;
            end
        end
    end

    // Parser state registers, updated on an accepted input transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_IDLE;
            slot_reg        <= '0;
            silence_reg     <= '0;
            echo_reg        <= '0;
            single_kind_reg <= RK_TX;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                cur_reg[i] <= '0;
            end
        end else if (cmd.accept) begin
            mode_reg        <= mode_next;
            slot_reg        <= slot_next;
            silence_reg     <= silence_next;
            echo_reg        <= echo_next;
            single_kind_reg <= single_kind_next;
            if (clear_levels) begin
                for (int i = 0; i < NUM_CHANNELS; i++) begin
                    cur_reg[i] <= '0;
                end
            end else if (store_level && mode_reg == MODE_CUR) begin
                cur_reg[slot_reg] <= rx[6:0];
            end
        end
    end

    // Default level store, written one entry per level transfer in default mode
    always_ff @(posedge aclk) begin
        if (cmd.accept && store_level && mode_reg == MODE_DEF) begin
            def_mem[slot_reg] <= rx[6:0];
        end
    end

    // Channel addressed by the current step
    assign ch_full = (cmd.seq == SEQ_CUR) ? step - STEP_W'(2) : step - STEP_W'(1);
    assign ch_idx  = ch_full[IDX_W-1:0];
    assign lvl_cur = cur_reg[ch_idx];
    assign lvl_def = def_mem[ch_idx];
    assign cur_on  = (lvl_cur >= off_threshold_reg);
    assign pwm_ch  = (ch_full == '0) || (ch_full == STEP_W'(NUM_CHANNELS - 1));
    assign pwm_sum = {2'b00, lvl_cur} + {1'b0, pwm_offset_reg};

    // Result for the current step of the running sequence
    always_comb begin
        res_kind = RK_TX;
        res_tx   = '0;
        res_ch   = '0;
        res_lvl  = '0;
        res_en   = 1'b0;
        case (cmd.seq)
            SEQ_ONE: begin
                res_kind = single_kind_reg;
                res_tx   = (single_kind_reg == RK_TX) ? echo_reg : 8'd0;
            end
            SEQ_IDENT: begin
                res_tx = ident_byte(step[3:0]);
            end
            SEQ_CUR: begin
                if (step == '0) begin
                    res_tx = BYTE_SET_DONE;
                end else if (step == STEP_W'(1)) begin
                    res_tx = echo_reg;
                end else begin
                    res_kind = RK_APPLY;
                    res_ch   = ch_full[2:0];
                    res_en   = cur_on;
                    if (cur_on) begin
                        if (pwm_ch) begin
                            res_lvl = pwm_sum[8] ? 8'hFF : pwm_sum[7:0];
                        end else begin
                            res_lvl = {1'b0, lvl_cur};
                        end
                    end
                end
            end
            SEQ_DEF: begin
                if (step == '0) begin
                    res_tx = BYTE_SET_DONE;
                end else if (step == STEP_W'(NUM_CHANNELS + 1)) begin
                    res_tx = echo_reg;
                end else begin
                    res_kind = RK_STORE;
                    res_ch   = ch_full[2:0];
                    res_lvl  = (lvl_def < off_threshold_reg) ? 8'd0 : {1'b0, lvl_def};
                end
            end
            default: ;
        endcase
    end

    // Output register: holds a result until the consumer takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            out_kind_reg <= res_kind;
            out_tx_reg   <= res_tx;
            out_ch_reg   <= res_ch;
            out_lvl_reg  <= res_lvl;
            out_en_reg   <= res_en;
            out_last_reg <= cmd.last;
        end
    end

    assign status.act_seq  = act_seq;
    assign status.out_free = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {4'b0000, out_en_reg, out_lvl_reg, out_ch_reg, out_tx_reg};

endmodule

FILE: rtl/fan_lvl_chk.sv
// Port-level checker for the fan level command parser, bound to the top level.
module fan_lvl_chk (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                cfg_we,
    input logic [fan_lvl_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input logic [fan_lvl_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic [fan_lvl_pkg::S_TDATA_W-1:0]   s_tdata,
    input logic                                s_tuser,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [fan_lvl_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic [fan_lvl_pkg::M_TUSER_W-1:0]   m_tuser,
    input logic                                m_tlast
);
    import fan_lvl_pkg::*;

    // No result is offered right after reset.
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result offered after reset");

    // A stalled result transfer keeps its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

    // A reset request is always the only and final result of its input.
    a_reset_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == RK_RESET |-> m_tlast && m_tdata == '0)
        else $error("reset request not final or not empty");

    // A disabled channel carries a zero level; a nonzero level comes only with enable or a store.
    a_enable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == RK_APPLY && m_tdata[19]) || m_tdata[18:11] == '0
            || m_tuser == RK_STORE)
        else $error("level without enable");

    // Transmit results carry no channel or level.
    a_tx_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == RK_TX |-> m_tdata[19:8] == '0)
        else $error("transmit result with channel data");

endmodule

bind fan_level_command_parser_top fan_lvl_chk u_chk (.*);
